// ----- rtl/trtd_pkg.sv -----
// Package of the run-length tile table decoder.
// Holds the transaction payload types, the register indexes and the constants.
// No dependencies.
package trtd_pkg;

  localparam int unsigned ROWS_DEF         = 16;
  localparam int unsigned ATTR_ENTRIES_DEF = 64;

  localparam logic [5:0] ROW_WIDTH_RESET = 6'd32;
  localparam logic [5:0] ATTR_SKIP_WIDTH = 6'h1C;
  localparam logic [7:0] COLUMN_MAX      = 8'hFF;
  localparam logic [7:0] ATTR_SKIP_STEP  = 8'd8;

  typedef enum logic [0:0] {
    REG_ROW_WIDTH  = 1'b0,
    REG_TABLE_MODE = 1'b1
  } reg_index_e;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       stream_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] run_value;
    logic [6:0] run_length;
    logic [3:0] row_index;
    logic [7:0] start_index;
    logic       table_done;
  } out_item_t;

  typedef struct packed {
    logic [5:0] row_width;
    logic       table_mode;
  } cfg_t;

endpackage

// ----- rtl/trtd_cfg.sv -----
// Configuration registers of the run-length tile table decoder.
// Depends on trtd_pkg for the register indexes and the configuration struct.
module trtd_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  trtd_pkg::reg_index_e wr_index_i,
  input  logic [5:0]          wr_data_i,
  output trtd_pkg::cfg_t      cfg_o
);

  trtd_pkg::cfg_t cfg_q;
  trtd_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        trtd_pkg::REG_ROW_WIDTH:  cfg_d.row_width  = wr_data_i;
        trtd_pkg::REG_TABLE_MODE: cfg_d.table_mode = wr_data_i[0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_width  <= trtd_pkg::ROW_WIDTH_RESET;
      cfg_q.table_mode <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/trtd_core.sv -----
// Decode state and combinational step logic of the run-length tile table decoder.
// Depends on trtd_pkg for the payload types, the configuration struct and constants.
module trtd_core #(
  parameter int unsigned ROWS         = trtd_pkg::ROWS_DEF,
  parameter int unsigned ATTR_ENTRIES = trtd_pkg::ATTR_ENTRIES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  trtd_pkg::in_item_t  item_i,
  input  trtd_pkg::cfg_t      cfg_i,
  output logic                res_valid_o,
  output trtd_pkg::out_item_t res_o
);

  localparam logic [1:0] PH_CONTROL = 2'd0;
  localparam logic [1:0] PH_REPEAT  = 2'd1;
  localparam logic [1:0] PH_LITERAL = 2'd2;

  localparam logic [4:0] RowsW = 5'(ROWS);
  localparam logic [8:0] AttrW = 9'(ATTR_ENTRIES);

  logic [1:0] phase_q, phase_d;
  logic [6:0] rem_q, rem_d;
  logic [7:0] col_q, col_d;
  logic [3:0] row_q, row_d;
  logic       fin_q, fin_d;

  logic [1:0] ph_e;
  logic [6:0] rem_e;
  logic [7:0] col_e;
  logic [3:0] row_e;
  logic       fin_e;
  logic       run_end;
  logic       emit;
  logic [6:0] len;
  logic [8:0] col_sum;
  logic [7:0] col_adv;
  logic [8:0] skip_sum;
  logic [7:0] col_end;
  logic [6:0] rem_dec;

  always_comb begin
    ph_e  = phase_q;
    rem_e = rem_q;
    col_e = col_q;
    row_e = row_q;
    fin_e = fin_q;
    if (item_i.stream_start) begin
      ph_e  = PH_CONTROL;
      rem_e = '0;
      col_e = '0;
      row_e = '0;
      fin_e = 1'b0;
    end

    run_end = 1'b0;
    emit    = 1'b0;
    len     = 7'd1;
    rem_dec = rem_e - 7'd1;
    phase_d = ph_e;
    rem_d   = rem_e;

    if (!fin_e) begin
      unique case (ph_e)
        PH_CONTROL: begin
          if (item_i.stream_byte[7] && (item_i.stream_byte[6:0] == 7'd0)) begin
            run_end = 1'b1;
          end else begin
            phase_d = item_i.stream_byte[7] ? PH_LITERAL : PH_REPEAT;
            rem_d   = item_i.stream_byte[6:0];
          end
        end
        PH_REPEAT: begin
          run_end = 1'b1;
          emit    = (rem_e != 7'd0);
          len     = rem_e;
        end
        PH_LITERAL: begin
          emit    = 1'b1;
          rem_d   = rem_dec;
          run_end = (rem_dec == 7'd0);
        end
        default: begin
          phase_d = PH_CONTROL;
        end
      endcase
    end

    col_sum = {1'b0, col_e} + {2'b00, len};
    col_adv = emit ? (col_sum[8] ? trtd_pkg::COLUMN_MAX : col_sum[7:0]) : col_e;

    col_d = col_adv;
    row_d = row_e;
    fin_d = fin_e;
    skip_sum = {1'b0, col_adv} + {1'b0, trtd_pkg::ATTR_SKIP_STEP};
    col_end  = col_adv;
    if (run_end) begin
      phase_d = PH_CONTROL;
      rem_d   = '0;
      if (!cfg_i.table_mode) begin
        if (col_adv >= {2'b00, cfg_i.row_width}) begin
          col_d = '0;
          if (({1'b0, row_e} + 5'd1) >= RowsW) begin
            fin_d = 1'b1;
          end else begin
            row_d = row_e + 4'd1;
          end
        end
      end else begin
        if ((col_adv[2:0] == 3'd0) && (cfg_i.row_width == trtd_pkg::ATTR_SKIP_WIDTH)) begin
          col_end = skip_sum[8] ? trtd_pkg::COLUMN_MAX : skip_sum[7:0];
        end
        col_d = col_end;
        if ({1'b0, col_end} >= AttrW) begin
          fin_d = 1'b1;
        end
      end
    end

    res_valid_o       = step_i && emit;
    res_o.run_value   = item_i.stream_byte;
    res_o.run_length  = len;
    res_o.row_index   = cfg_i.table_mode ? 4'd0 : row_e;
    res_o.start_index = col_e;
    res_o.table_done  = run_end && fin_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CONTROL;
      rem_q   <= '0;
      col_q   <= '0;
      row_q   <= '0;
      fin_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      col_q   <= col_d;
      row_q   <= row_d;
      fin_q   <= fin_d;
    end
  end

endmodule

// ----- rtl/tile_rle_table_decoder_top.sv -----
// Top level of the run-length tile table decoder.
// Instantiates trtd_cfg and trtd_core; uses trtd_pkg for payload types and constants.
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid_i/in_ready_o   in_data_i (stream byte, start mark)
//   out      output     out_valid_o/out_ready_i out_data_o (one table segment)
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A transaction is registered on input, decoded combinationally and any segment is
// registered on output.
// One input transaction is taken every cycle while the output is not stalled.
// Reset clears the decode state and sets the registers to width 32, tile mode.
// A stalled output holds the input register, which then holds the input channel.
module tile_rle_table_decoder_top #(
  parameter int unsigned ROWS         = trtd_pkg::ROWS_DEF,
  parameter int unsigned ATTR_ENTRIES = trtd_pkg::ATTR_ENTRIES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  trtd_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output trtd_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [0:0]          cfg_index_i,
  input  logic [5:0]          cfg_data_i
);

  logic                in_valid_q;
  trtd_pkg::in_item_t  in_data_q;
  logic                out_valid_q;
  trtd_pkg::out_item_t out_data_q;
  logic                step;
  logic                res_valid;
  trtd_pkg::out_item_t res;
  trtd_pkg::cfg_t      cfg;

  assign step        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || step;
  assign cfg_ready_o = 1'b1;

  trtd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (trtd_pkg::reg_index_e'(cfg_index_i)),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  trtd_core #(
    .ROWS         (ROWS),
    .ATTR_ENTRIES (ATTR_ENTRIES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (in_data_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (step) begin
        out_valid_q <= res_valid;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
    if (step && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- tb/trtd_segment_checker.sv -----
// Checker of the run-length tile table decoder: watches the three channels, predicts
// each segment from the accepted stream bytes and register writes, and compares.
// Depends on trtd_pkg for the payload types, register indexes and constants.
`timescale 1ns / 100ps

module trtd_segment_checker #(
  parameter int unsigned ROWS         = trtd_pkg::ROWS_DEF,
  parameter int unsigned ATTR_ENTRIES = trtd_pkg::ATTR_ENTRIES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  trtd_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  trtd_pkg::out_item_t out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [0:0]          cfg_index_i,
  input  logic [5:0]          cfg_data_i,
  output int unsigned         pending_o,
  output int unsigned         fail_count_o
);

  typedef enum logic [1:0] {
    DEC_CONTROL,
    DEC_REPEAT,
    DEC_LITERAL
  } dec_phase_e;

  logic [5:0]          row_width_q;
  logic                attr_mode_q;
  dec_phase_e          phase_q;
  logic [6:0]          run_left_q;
  logic [7:0]          column_q;
  logic [3:0]          row_q;
  logic                table_full_q;
  trtd_pkg::out_item_t segments_due[$];
  trtd_pkg::out_item_t want;

  function automatic void add_columns(input logic [7:0] amount);
    logic [8:0] sum;
    sum = {1'b0, column_q} + {1'b0, amount};
    column_q = (sum > {1'b0, trtd_pkg::COLUMN_MAX}) ? trtd_pkg::COLUMN_MAX : sum[7:0];
  endfunction

  function automatic void close_run();
    phase_q    = DEC_CONTROL;
    run_left_q = '0;
    if (!attr_mode_q) begin
      if (column_q >= row_width_q) begin
        column_q = '0;
        if (row_q + 1 >= ROWS) begin
          table_full_q = 1'b1;
        end else begin
          row_q = row_q + 4'd1;
        end
      end
    end else begin
      if (column_q[2:0] == 3'd0 && row_width_q == trtd_pkg::ATTR_SKIP_WIDTH) begin
        add_columns(trtd_pkg::ATTR_SKIP_STEP);
      end
      if (column_q >= ATTR_ENTRIES) begin
        table_full_q = 1'b1;
      end
    end
  endfunction

  function automatic void decode_stream_byte(input trtd_pkg::in_item_t item);
    trtd_pkg::out_item_t seg;
    if (item.stream_start) begin
      phase_q      = DEC_CONTROL;
      run_left_q   = '0;
      column_q     = '0;
      row_q        = '0;
      table_full_q = 1'b0;
    end else if (table_full_q) begin
      return;
    end
    seg.run_value   = item.stream_byte;
    seg.row_index   = attr_mode_q ? 4'd0 : row_q;
    seg.start_index = column_q;
    seg.table_done  = 1'b0;
    case (phase_q)
      DEC_CONTROL: begin
        run_left_q = item.stream_byte[6:0];
        if (!item.stream_byte[7]) begin
          phase_q = DEC_REPEAT;
        end else if (item.stream_byte[6:0] == 7'd0) begin
          close_run();
        end else begin
          phase_q = DEC_LITERAL;
        end
      end
      DEC_REPEAT: begin
        if (run_left_q == 7'd0) begin
          close_run();
        end else begin
          seg.run_length = run_left_q;
          add_columns({1'b0, run_left_q});
          close_run();
          seg.table_done = table_full_q;
          segments_due.push_back(seg);
        end
      end
      default: begin
        seg.run_length = 7'd1;
        add_columns(8'd1);
        run_left_q = run_left_q - 7'd1;
        if (run_left_q == 7'd0) begin
          close_run();
          seg.table_done = table_full_q;
        end
        segments_due.push_back(seg);
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [7:0] expected,
                                      input logic [7:0] actual);
    if (actual !== expected) begin
      $error("%s: expected %0h, actual %0h", name, expected, actual);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q  = trtd_pkg::ROW_WIDTH_RESET;
      attr_mode_q  = 1'b0;
      phase_q      = DEC_CONTROL;
      run_left_q   = '0;
      column_q     = '0;
      row_q        = '0;
      table_full_q = 1'b0;
      segments_due.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (segments_due.size() == 0) begin
          $error("segment with none expected: value %0h, length %0d, start %0d",
                 out_data_i.run_value, out_data_i.run_length, out_data_i.start_index);
          fail_count_o++;
        end else begin
          want = segments_due.pop_front();
          check_field("run_value", want.run_value, out_data_i.run_value);
          check_field("run_length", 8'(want.run_length), 8'(out_data_i.run_length));
          check_field("row_index", 8'(want.row_index), 8'(out_data_i.row_index));
          check_field("start_index", want.start_index, out_data_i.start_index);
          check_field("table_done", 8'(want.table_done), 8'(out_data_i.table_done));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (trtd_pkg::reg_index_e'(cfg_index_i) == trtd_pkg::REG_ROW_WIDTH) begin
          row_width_q = cfg_data_i;
        end else begin
          attr_mode_q = cfg_data_i[0];
        end
      end
      if (in_valid_i && in_ready_i) begin
        decode_stream_byte(in_data_i);
      end
      pending_o = segments_due.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
// Top of the run-length tile table decoder testbench: clock, reset, stream stimulus,
// register writes and the verdict. Depends on trtd_pkg, the decoder top level and
// trtd_segment_checker, which predicts and compares every segment.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned ITEM_TARGET  = 1750;
  localparam int unsigned PHASES       = 12;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  trtd_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  trtd_pkg::out_item_t out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [0:0]          cfg_index;
  logic [5:0]          cfg_data;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned items_sent = 0;
  int unsigned hold_left  = 0;
  bit          quiet      = 1'b0;

  logic [5:0] phase_width [0:7] = '{6'd1, 6'd28, 6'd0, 6'd63, 6'd28, 6'd5, 6'd60, 6'd2};
  logic       phase_mode  [0:7] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

  tile_rle_table_decoder_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  trtd_segment_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    #3_200_000;
    $display("FAIL");
    $finish;
  end

  // The receiver stalls at random, or for a counted stretch when asked to hold off.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= quiet || ($urandom_range(0, 99) >= 38);
      end
    end
  end

  task automatic send_byte(input logic [7:0] value, input logic first);
    while (!quiet && $urandom_range(0, 99) < 38) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{stream_byte: value, stream_start: first};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_run(input logic first);
    int unsigned pick;
    int unsigned count;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      send_byte(8'h80, first);
    end else if (pick < 10) begin
      send_byte(8'h00, first);
      send_byte(8'($urandom), 1'b0);
    end else if (pick < 50) begin
      count = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 4);
      send_byte({1'b1, 7'(count)}, first);
      repeat (count) send_byte(8'($urandom), $urandom_range(0, 99) == 0);
    end else begin
      count = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 16);
      send_byte({1'b0, 7'(count)}, first);
      send_byte(8'($urandom), $urandom_range(0, 99) == 0);
    end
  endtask

  task automatic send_table();
    int unsigned runs;
    runs = $urandom_range(3, 40);
    send_run(1'b1);
    repeat (runs - 1) send_run(1'b0);
    if ($urandom_range(0, 3) == 0) begin
      send_byte(8'($urandom), 1'b0);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input trtd_pkg::reg_index_e index, input logic [5:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic configure(input logic [5:0] width, input logic mode);
    wait_idle();
    write_reg(trtd_pkg::REG_ROW_WIDTH, width);
    write_reg(trtd_pkg::REG_TABLE_MODE, {5'($urandom), mode});
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned phase_end;
    logic [5:0]  width;
    logic        mode;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = trtd_pkg::REG_ROW_WIDTH;
    cfg_data  = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Tile mode at the reset width: repeats, literals, empty runs and a restart mid-run.
    send_byte(8'h05, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h83, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h77, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h81, 1'b1);
    send_byte(8'hC3, 1'b0);

    // Attribute table with skipping: completion, ignored bytes, then an empty run.
    configure(trtd_pkg::ATTR_SKIP_WIDTH, 1'b1);
    send_byte(8'h08, 1'b1);
    send_byte(8'h11, 1'b0);
    send_byte(8'h30, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h05, 1'b0);
    send_byte(8'h85, 1'b0);
    send_byte(8'h80, 1'b1);

    for (int unsigned p = 0; p < PHASES; p++) begin
      if (p < 8) begin
        width = phase_width[p];
        mode  = phase_mode[p];
      end else begin
        mode  = 1'($urandom_range(0, 1));
        width = ($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 8)) : 6'($urandom);
        if (mode && $urandom_range(0, 1) == 0) begin
          width = trtd_pkg::ATTR_SKIP_WIDTH;
        end
      end
      configure(width, mode);
      quiet = (p == 3);
      if (p == 5) begin
        hold_left = HOLD_CYCLES;
      end
      phase_end = (p + 1) * ITEM_TARGET / PHASES;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
        end else begin
          send_table();
        end
      end
    end

    quiet = 1'b0;
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- tile_rle_table_decoder_top.f -----
rtl/trtd_pkg.sv
rtl/trtd_cfg.sv
rtl/trtd_core.sv
rtl/tile_rle_table_decoder_top.sv
tb/trtd_segment_checker.sv
tb/testbench.sv
